>>> hw/rtl/wosc_adsr_pkg.sv
// ----------------------------------------------------------------------------
// wosc_adsr_pkg
// Types, codes and the sine table function shared by the oscillator and
// envelope core.
// ----------------------------------------------------------------------------
package wosc_adsr_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] UNITY        = 16'h8000;
   localparam logic [15:0] LFSR_SEED    = 16'hACE1;
   localparam logic [15:0] LFSR_MASK    = 16'hB400;
   localparam logic [15:0] NOISE_OFFSET = 16'h4000;
   localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_KEY_ON  = 2'd1;
   localparam logic [1:0] CMD_KEY_OFF = 2'd2;

   localparam logic [2:0] WAVE_SINE     = 3'd0;
   localparam logic [2:0] WAVE_SQUARE   = 3'd1;
   localparam logic [2:0] WAVE_SAW      = 3'd2;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
   localparam logic [2:0] WAVE_NOISE    = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_WAVE_TYPE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_STEP   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_STEP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_STEP  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUSTAIN_LEVEL = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME        = 3'd5;

   typedef enum logic [2:0] {
      ADSR_IDLE    = 3'd0,
      ADSR_ATTACK  = 3'd1,
      ADSR_DECAY   = 3'd2,
      ADSR_SUSTAIN = 3'd3,
      ADSR_RELEASE = 3'd4
   } env_state_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_ENV,
      SEQ_WAVE,
      SEQ_FORM,
      SEQ_MUL1,
      SEQ_MUL2,
      SEQ_SAT,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        voice;
      logic [15:0] phase;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic [15:0]        level;
      logic [2:0]         env_phase;
   } rsp_type;

   // Sine of a Q32 turn fraction, evaluated as a Q30 Taylor series and
   // rounded to Q15. Used only to build constant tables.
   function automatic logic signed [15:0] sine_q15(input logic [63:0] f);
      logic [1:0]  quad;
      logic [63:0] u;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      quad = f[31:30];
      u    = {34'd0, f[29:0]};
      if (quad[0]) begin
         u = (64'd1 << 30) - u;
      end
      x  = (u * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = (64'd1 << 30) - x2 / 64'd110;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      s  = (s + (64'd1 << 14)) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return quad[1] ? 16'(-s) : 16'(s);
   endfunction

endpackage

>>> hw/rtl/waveform_oscillator_adsr_envelope_core.sv
// ----------------------------------------------------------------------------
// waveform_oscillator_adsr_envelope_core
// Per-voice linear ADSR envelope with a sine, square, saw, triangle or noise
// oscillator, scaled by envelope level and volume in Q1.15.
// ----------------------------------------------------------------------------
// Each request addresses one voice. A key-on or key-off request runs from
// acceptance through the envelope step to the hand-off, and a sample tick
// runs through the envelope step, the sine table read, forming the wave
// value, two passes through the single 32x16 multiplier (wave times level,
// then times volume) and saturation, followed by the hand-off to the
// response register. The core takes one request at a time,
// and req_stall stays high until the previous response has been moved into
// the output register. The response register lets the next request start
// while a finished response is still waiting. Configuration writes are always
// accepted and are expected only while the core is idle.
module waveform_oscillator_adsr_envelope_core #(
   parameter int VOICES           = 2,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  wosc_adsr_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output wosc_adsr_pkg::rsp_type                 rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wosc_adsr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wosc_adsr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);

   wosc_adsr_pkg::seq_state_type seq_ff, seq_in;

   logic [1:0]  cmd_ff;
   logic        voice_ff;
   logic [15:0] phase_ff;

   wosc_adsr_pkg::env_state_type env_state_ff [VOICES];
   logic [15:0]                  env_level_ff [VOICES];
   wosc_adsr_pkg::env_state_type env_state_in;
   logic [15:0]                  env_level_in;
   logic                         env_we;

   logic [15:0] lfsr_ff, lfsr_in;

   logic [2:0]  wave_type_ff;
   logic [15:0] attack_ff;
   logic [15:0] decay_ff;
   logic [15:0] release_ff;
   logic [15:0] sustain_ff;
   logic [15:0] volume_ff;

   logic [47:0]        prod_ff, prod_in;
   logic signed [15:0] sine_ff;
   logic               neg_ff, neg_in;
   logic [15:0]        mag_ff, mag_in;
   logic signed [15:0] res_sample_ff, res_sample_in;
   logic [15:0]        res_level_ff, res_level_in;
   logic [2:0]         res_phase_ff, res_phase_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   wosc_adsr_pkg::rsp_type rsp_data_ff;
   logic                   rsp_load;

   logic [31:0] mul_a;
   logic [15:0] mul_b;
   logic [47:0] mul_p;

   logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

   logic [VIDX_W-1:0]            vidx;
   logic                         voice_ok;
   wosc_adsr_pkg::env_state_type cur_state;
   logic [15:0]                  cur_level;
   logic [15:0]                  sus;
   logic [16:0]                  att_sum;
   logic [15:0]                  dec_diff;
   logic [15:0]                  rel_diff;
   logic                         first_half;
   logic [15:0]                  noise_val;
   logic [17:0]                  sat_mag;
   logic                         req_fire;

   for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_sine
      localparam logic [63:0] F = (64'(i) << 32) / SINE_TABLE_DEPTH;
      assign sine_rom[i] = wosc_adsr_pkg::sine_q15(F);
   end

   assign req_stall = (seq_ff != wosc_adsr_pkg::SEQ_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign vidx      = VIDX_W'(voice_ff);
   assign voice_ok  = (32'(voice_ff) < VOICES);
   assign cur_state = env_state_ff[vidx];
   assign cur_level = env_level_ff[vidx];
   assign sus       = (sustain_ff > wosc_adsr_pkg::UNITY) ? wosc_adsr_pkg::UNITY : sustain_ff;
   assign att_sum   = {1'b0, cur_level} + {1'b0, attack_ff};
   assign dec_diff  = cur_level - decay_ff;
   assign rel_diff  = cur_level - release_ff;
   assign first_half = (phase_ff <= 16'd32768);
   assign noise_val = {1'b0, lfsr_ff[15:1]};
   assign sat_mag   = prod_ff[47:30];

   assign mul_p = mul_a * mul_b;

   always_comb begin
      seq_in        = seq_ff;
      env_we        = 1'b0;
      env_state_in  = cur_state;
      env_level_in  = cur_level;
      lfsr_in       = lfsr_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      res_sample_in = res_sample_ff;
      res_level_in  = res_level_ff;
      res_phase_in  = res_phase_ff;
      rsp_load      = 1'b0;
      mul_a         = 32'(SINE_TABLE_DEPTH);
      mul_b         = phase_ff;

      case (seq_ff)
         wosc_adsr_pkg::SEQ_IDLE: begin
            if (req_fire) begin
               seq_in = wosc_adsr_pkg::SEQ_ENV;
            end
         end
         wosc_adsr_pkg::SEQ_ENV: begin
            prod_in       = mul_p;
            res_sample_in = '0;
            seq_in        = wosc_adsr_pkg::SEQ_DONE;
            case (cmd_ff)
               wosc_adsr_pkg::CMD_KEY_ON: begin
                  env_state_in = wosc_adsr_pkg::ADSR_ATTACK;
                  env_we       = 1'b1;
               end
               wosc_adsr_pkg::CMD_KEY_OFF: begin
                  env_state_in = wosc_adsr_pkg::ADSR_RELEASE;
                  env_we       = 1'b1;
               end
               wosc_adsr_pkg::CMD_TICK: begin
                  env_we = 1'b1;
                  seq_in = wosc_adsr_pkg::SEQ_WAVE;
                  case (cur_state)
                     wosc_adsr_pkg::ADSR_ATTACK: begin
                        if (att_sum >= {1'b0, wosc_adsr_pkg::UNITY}) begin
                           env_level_in = wosc_adsr_pkg::UNITY;
                           env_state_in = wosc_adsr_pkg::ADSR_DECAY;
                        end else begin
                           env_level_in = att_sum[15:0];
                        end
                     end
                     wosc_adsr_pkg::ADSR_DECAY: begin
                        if (decay_ff >= cur_level || dec_diff <= sus) begin
                           env_level_in = sus;
                           env_state_in = wosc_adsr_pkg::ADSR_SUSTAIN;
                        end else begin
                           env_level_in = dec_diff;
                        end
                     end
                     wosc_adsr_pkg::ADSR_RELEASE: begin
                        if (release_ff >= cur_level) begin
                           env_level_in = '0;
                           env_state_in = wosc_adsr_pkg::ADSR_IDLE;
                        end else begin
                           env_level_in = rel_diff;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               default: begin
               end
            endcase
            res_level_in = env_level_in;
            res_phase_in = env_state_in;
            if (!voice_ok) begin
               env_we       = 1'b0;
               res_level_in = '0;
               res_phase_in = '0;
               seq_in       = wosc_adsr_pkg::SEQ_DONE;
            end
         end
         wosc_adsr_pkg::SEQ_WAVE: begin
            if (wave_type_ff == wosc_adsr_pkg::WAVE_NOISE) begin
               lfsr_in = lfsr_ff[0] ? ({1'b0, lfsr_ff[15:1]} ^ wosc_adsr_pkg::LFSR_MASK)
                                    : {1'b0, lfsr_ff[15:1]};
            end
            seq_in = wosc_adsr_pkg::SEQ_FORM;
         end
         wosc_adsr_pkg::SEQ_FORM: begin
            neg_in = 1'b0;
            mag_in = '0;
            case (wave_type_ff)
               wosc_adsr_pkg::WAVE_SINE: begin
                  neg_in = sine_ff[15];
                  mag_in = sine_ff[15] ? 16'(-sine_ff) : sine_ff;
               end
               wosc_adsr_pkg::WAVE_SQUARE: begin
                  neg_in = !first_half;
                  mag_in = wosc_adsr_pkg::UNITY;
               end
               wosc_adsr_pkg::WAVE_SAW: begin
                  neg_in = !first_half;
                  mag_in = first_half ? phase_ff : 16'(17'h10000 - {1'b0, phase_ff});
               end
               wosc_adsr_pkg::WAVE_TRIANGLE: begin
                  mag_in = first_half ? phase_ff : 16'(17'h10000 - {1'b0, phase_ff});
               end
               wosc_adsr_pkg::WAVE_NOISE: begin
                  if (noise_val >= wosc_adsr_pkg::NOISE_OFFSET) begin
                     mag_in = noise_val - wosc_adsr_pkg::NOISE_OFFSET;
                  end else begin
                     neg_in = 1'b1;
                     mag_in = wosc_adsr_pkg::NOISE_OFFSET - noise_val;
                  end
               end
               default: begin
               end
            endcase
            seq_in = wosc_adsr_pkg::SEQ_MUL1;
         end
         wosc_adsr_pkg::SEQ_MUL1: begin
            mul_a   = {16'd0, mag_ff};
            mul_b   = res_level_ff;
            prod_in = mul_p;
            seq_in  = wosc_adsr_pkg::SEQ_MUL2;
         end
         wosc_adsr_pkg::SEQ_MUL2: begin
            mul_a   = prod_ff[31:0];
            mul_b   = volume_ff;
            prod_in = mul_p;
            seq_in  = wosc_adsr_pkg::SEQ_SAT;
         end
         wosc_adsr_pkg::SEQ_SAT: begin
            if (neg_ff) begin
               res_sample_in = (sat_mag > 18'd32768) ? 16'sh8000 : 16'(-sat_mag);
            end else begin
               res_sample_in = (sat_mag > 18'd32767) ? 16'sh7FFF : 16'(sat_mag);
            end
            seq_in = wosc_adsr_pkg::SEQ_DONE;
         end
         wosc_adsr_pkg::SEQ_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               seq_in   = wosc_adsr_pkg::SEQ_IDLE;
            end
         end
         default: begin
            seq_in = wosc_adsr_pkg::SEQ_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= wosc_adsr_pkg::SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         lfsr_ff      <= wosc_adsr_pkg::LFSR_SEED;
         wave_type_ff <= wosc_adsr_pkg::WAVE_SINE;
         attack_ff    <= wosc_adsr_pkg::UNITY;
         decay_ff     <= wosc_adsr_pkg::UNITY;
         release_ff   <= wosc_adsr_pkg::UNITY;
         sustain_ff   <= wosc_adsr_pkg::UNITY;
         volume_ff    <= '0;
         for (int v = 0; v < VOICES; v++) begin
            env_state_ff[v] <= wosc_adsr_pkg::ADSR_IDLE;
            env_level_ff[v] <= '0;
         end
      end else begin
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         lfsr_ff      <= lfsr_in;
         if (env_we) begin
            env_state_ff[vidx] <= env_state_in;
            env_level_ff[vidx] <= env_level_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               wosc_adsr_pkg::CSR_WAVE_TYPE:     wave_type_ff <= csr_wdata[2:0];
               wosc_adsr_pkg::CSR_ATTACK_STEP:   attack_ff    <= csr_wdata;
               wosc_adsr_pkg::CSR_DECAY_STEP:    decay_ff     <= csr_wdata;
               wosc_adsr_pkg::CSR_RELEASE_STEP:  release_ff   <= csr_wdata;
               wosc_adsr_pkg::CSR_SUSTAIN_LEVEL: sustain_ff   <= csr_wdata;
               wosc_adsr_pkg::CSR_VOLUME:        volume_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_data.cmd;
         voice_ff <= req_data.voice;
         phase_ff <= req_data.phase;
      end
      if (seq_ff == wosc_adsr_pkg::SEQ_WAVE) begin
         sine_ff <= sine_rom[prod_ff[16 +: IDX_W]];
      end
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      res_sample_ff <= res_sample_in;
      res_level_ff  <= res_level_in;
      res_phase_ff  <= res_phase_in;
      if (rsp_load) begin
         rsp_data_ff.sample    <= res_sample_ff;
         rsp_data_ff.level     <= res_level_ff;
         rsp_data_ff.env_phase <= res_phase_ff;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts_env: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> seq_ff == wosc_adsr_pkg::SEQ_ENV)
      else $error("Accepted request did not start the envelope step.");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      seq_ff == wosc_adsr_pkg::SEQ_MUL1 |-> res_level_ff <= wosc_adsr_pkg::UNITY)
      else $error("Envelope level exceeds unity.");

   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != 16'd0)
      else $error("Noise LFSR reached the all-zero state.");

   a_key_sample_zero: assert property (@(posedge clock) disable iff (reset)
      seq_ff == wosc_adsr_pkg::SEQ_DONE && cmd_ff != wosc_adsr_pkg::CMD_TICK
      |-> res_sample_ff == 16'sd0)
      else $error("Non-tick request carries a nonzero sample.");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(seq_ff) == wosc_adsr_pkg::SEQ_DONE)
      else $error("Response raised outside the hand-off step.");
`endif

endmodule
